// File: rtl/kbd_xlat_pkg.sv
// ----------------------------------------------------------------------------
// kbd_xlat_pkg
// types and constants shared by the keyboard scan code translator
// ----------------------------------------------------------------------------
package kbd_xlat_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int INDEX_BITS    = $clog2(TABLE_ENTRIES);
    localparam int CODE_BITS     = 16;
    localparam int BYTE_BITS     = 8;
    localparam int SEL_BITS      = 2;
    localparam int ACTION_BITS   = 2;
    localparam int CFG_ADDR_BITS = 1;

    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 24;

    // command kinds on tuser
    localparam logic CMD_KEY   = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // table selects
    localparam logic [SEL_BITS-1:0] TBL_NORMAL  = 2'd0;
    localparam logic [SEL_BITS-1:0] TBL_SHIFTED = 2'd1;
    localparam logic [SEL_BITS-1:0] TBL_FUNC    = 2'd2;
    localparam logic [SEL_BITS-1:0] TBL_KEYPAD  = 2'd3;

    // result actions
    localparam logic [ACTION_BITS-1:0] ACT_PRESS       = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_RELEASE     = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_RELEASE_ALL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_NO_KEY     = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SHIFT_LOCK = 1'b1;

    localparam logic [CODE_BITS-1:0] NO_KEY_RESET     = 16'hFFFF;
    localparam logic [CODE_BITS-1:0] SHIFT_LOCK_RESET = 16'd15;

    // special matrix codes
    localparam logic [INDEX_BITS-1:0] KEY_LEFT_SHIFT  = 7'd88;
    localparam logic [INDEX_BITS-1:0] KEY_RIGHT_SHIFT = 7'd89;
    localparam logic [INDEX_BITS-1:0] KEY_FN          = 7'd34;
    localparam logic [INDEX_BITS-1:0] KEY_KEYPAD_LOCK = 7'd49;

    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        logic [CODE_BITS-1:0]   code;
    } t_result;

endpackage

// File: rtl/keyboard_scancode_translator_core.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_translator_core
// translates raw keyboard bytes into press, release and release-all events
// ----------------------------------------------------------------------------
// usage
//   s_axis: one transaction per item; tuser = command (0 key byte, 1 table
//   write), tdata carries key byte, table select, table index, entry value.
//   m_axis: one transaction per result; tdata = action and key code, tlast
//   marks the final result of an input item. table writes give no result.
//   cfg: i_cfg_we writes i_cfg_data to register i_cfg_addr.
// timing
//   an item is registered together with its four table reads on accept, and
//   its results are then formed into the output register once that is free.
//   one item per cycle is taken while items give at most one result and the
//   receiver does not stall; an item with two results fills the single output
//   register and its spare, and the next item waits until both are taken.
// reset
//   clears the modifier flags, previous byte, pipeline and output valids and
//   restores the registers; tables keep their contents and must be loaded.
//   a stalled receiver holds the output and backs up into s_axis_tready.
// ----------------------------------------------------------------------------
module keyboard_scancode_translator_core
    import kbd_xlat_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // scan_byte[7:0], table_select[9:8], table_index[16:10], entry_value[32:17]
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // command[0]
    input  logic                     s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // action[1:0], event_code[17:2]
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic                     m_axis_tlast,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CODE_BITS-1:0]     i_cfg_data
);

    logic [CODE_BITS-1:0] r_normal_mem  [TABLE_ENTRIES];
    logic [CODE_BITS-1:0] r_shifted_mem [TABLE_ENTRIES];
    logic [CODE_BITS-1:0] r_func_mem    [TABLE_ENTRIES];
    logic                 r_keypad_mem  [TABLE_ENTRIES];

    logic [BYTE_BITS-1:0]  in_scan_byte;
    logic [SEL_BITS-1:0]   in_sel;
    logic [INDEX_BITS-1:0] in_index;
    logic [CODE_BITS-1:0]  in_value;
    logic                  in_accept;

    logic [CODE_BITS-1:0] r_no_key;
    logic [CODE_BITS-1:0] r_shift_lock_code;

    logic                 r_s1_valid;
    logic                 r_s1_cmd;
    logic [BYTE_BITS-1:0] r_s1_byte;
    logic [CODE_BITS-1:0] r_normal_rd;
    logic [CODE_BITS-1:0] r_shifted_rd;
    logic [CODE_BITS-1:0] r_func_rd;
    logic                 r_keypad_rd;

    logic                 r_fn_held, n_fn_held;
    logic                 r_lshift, n_lshift;
    logic                 r_rshift, n_rshift;
    logic                 r_keypad_lock, n_keypad_lock;
    logic                 r_caps_lock, n_caps_lock;
    logic [BYTE_BITS-1:0] r_prev_byte, n_prev_byte;

    logic                  up;
    logic [INDEX_BITS-1:0] m;
    logic [CODE_BITS-1:0]  code;
    logic                  toggle;
    logic                  fn_next;
    t_result               res0, res1;
    logic [1:0]            res_cnt;

    logic    out_free, s1_go, load;
    logic    r_out_valid, r_out_last, r_pend_valid;
    t_result r_out, r_pend;

    assign in_scan_byte = s_axis_tdata[7:0];
    assign in_sel       = s_axis_tdata[9:8];
    assign in_index     = s_axis_tdata[16:10];
    assign in_value     = s_axis_tdata[32:17];

    assign s_axis_tready = !r_s1_valid || s1_go;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // table storage and table reads for the accepted item
    always_ff @(posedge i_clk) begin
        if (in_accept && s_axis_tuser == CMD_WRITE) begin
            unique case (in_sel)
                TBL_NORMAL:  r_normal_mem[in_index]  <= in_value;
                TBL_SHIFTED: r_shifted_mem[in_index] <= in_value;
                TBL_FUNC:    r_func_mem[in_index]    <= in_value;
                TBL_KEYPAD:  r_keypad_mem[in_index]  <= in_value[0];
            endcase
        end
        if (in_accept) begin
            r_s1_cmd     <= s_axis_tuser;
            r_s1_byte    <= in_scan_byte;
            r_normal_rd  <= r_normal_mem[in_scan_byte[INDEX_BITS-1:0]];
            r_shifted_rd <= r_shifted_mem[in_scan_byte[INDEX_BITS-1:0]];
            r_func_rd    <= r_func_mem[in_scan_byte[INDEX_BITS-1:0]];
            r_keypad_rd  <= r_keypad_mem[in_scan_byte[INDEX_BITS-1:0]];
        end
    end

    // translation
    assign up = r_s1_byte[BYTE_BITS-1];
    assign m  = r_s1_byte[INDEX_BITS-1:0];

    always_comb begin
        priority if (r_fn_held && (!r_keypad_lock || !r_keypad_rd)) begin
            code = (r_func_rd != r_no_key) ? r_func_rd : r_no_key;
        end else if ((r_caps_lock || r_lshift || r_rshift) && r_shifted_rd != r_no_key) begin
            code = r_shifted_rd;
        end else if (r_keypad_lock && !r_fn_held && r_keypad_rd) begin
            code = r_func_rd;
        end else begin
            code = r_normal_rd;
        end
    end

    assign toggle  = r_fn_held && !up
                     && ((r_lshift && m == KEY_RIGHT_SHIFT) || (r_rshift && m == KEY_LEFT_SHIFT));
    assign fn_next = (m == KEY_FN) ? !up : r_fn_held;

    always_comb begin
        n_fn_held     = r_fn_held;
        n_lshift      = r_lshift;
        n_rshift      = r_rshift;
        n_keypad_lock = r_keypad_lock;
        n_caps_lock   = r_caps_lock;
        n_prev_byte   = r_prev_byte;
        res0          = '{action: ACT_RELEASE_ALL, code: '0};
        res1          = '{action: ACT_PRESS, code: r_shift_lock_code};
        res_cnt       = 2'd0;
        if (r_s1_cmd == CMD_KEY) begin
            n_prev_byte = r_s1_byte;
            priority if (r_s1_byte == r_prev_byte) begin
                res_cnt = r_caps_lock ? 2'd2 : 2'd1;
            end else if (code != r_no_key) begin
                if (toggle) begin
                    n_caps_lock = !r_caps_lock;
                    res0 = '{action: r_caps_lock ? ACT_RELEASE : ACT_PRESS,
                             code: r_shift_lock_code};
                    res1 = '{action: up ? ACT_RELEASE : ACT_PRESS, code: code};
                    res_cnt = 2'd2;
                end else begin
                    res0 = '{action: up ? ACT_RELEASE : ACT_PRESS, code: code};
                    res_cnt = 2'd1;
                end
                if (m == KEY_LEFT_SHIFT) begin
                    n_lshift = !up;
                end else if (m == KEY_RIGHT_SHIFT) begin
                    n_rshift = !up;
                end
            end else begin
                n_fn_held = fn_next;
                if (fn_next && m == KEY_KEYPAD_LOCK && !up) begin
                    n_keypad_lock = !r_keypad_lock;
                end
            end
        end
    end

    // output register with spare slot for the second result
    assign out_free = !r_out_valid || (m_axis_tready && !r_pend_valid);
    assign s1_go    = r_s1_valid && (res_cnt == 2'd0 || out_free);
    assign load     = s1_go && res_cnt != 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_key          <= NO_KEY_RESET;
            r_shift_lock_code <= SHIFT_LOCK_RESET;
            r_s1_valid        <= 1'b0;
            r_fn_held         <= 1'b0;
            r_lshift          <= 1'b0;
            r_rshift          <= 1'b0;
            r_keypad_lock     <= 1'b0;
            r_caps_lock       <= 1'b0;
            r_prev_byte       <= '0;
            r_out_valid       <= 1'b0;
            r_pend_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_NO_KEY:     r_no_key          <= i_cfg_data;
                    CFG_SHIFT_LOCK: r_shift_lock_code <= i_cfg_data;
                endcase
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_fn_held     <= n_fn_held;
                r_lshift      <= n_lshift;
                r_rshift      <= n_rshift;
                r_keypad_lock <= n_keypad_lock;
                r_caps_lock   <= n_caps_lock;
                r_prev_byte   <= n_prev_byte;
            end
            if (load) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= (res_cnt == 2'd2);
            end else if (r_out_valid && m_axis_tready) begin
                if (r_pend_valid) begin
                    r_pend_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out      <= res0;
            r_out_last <= (res_cnt == 2'd1);
            r_pend     <= res1;
        end else if (r_out_valid && m_axis_tready && r_pend_valid) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{(OUT_DATA_BITS-CODE_BITS-ACTION_BITS){1'b0}},
                            r_out.code, r_out.action};

endmodule
